// ===== hdl/eaf_pkg.sv =====
// ----------------------------------------------------------------------------
// eaf_pkg
// shared types and constants of the elastic audio fifo
// ----------------------------------------------------------------------------
package eaf_pkg;

    localparam int FRAME_W        = 32;
    localparam int REG_W          = 14;
    localparam int NUM_REGS       = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int TDATA_W        = 48;
    localparam int TUSER_W        = 1;
    localparam int RING_DEPTH_DEF = 16384;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FRAMES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_FRAMES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_CONSUME = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MILD_CONSUME   = 3'd5;

    // register reset values
    localparam logic [REG_W-1:0] BLOCK_FRAMES_RST   = 14'd800;
    localparam logic [REG_W-1:0] STRETCH_FRAMES_RST = 14'd800;
    localparam logic [REG_W-1:0] LOW_THRESHOLD_RST  = 14'd1600;
    localparam logic [REG_W-1:0] HIGH_THRESHOLD_RST = 14'd2400;
    localparam logic [REG_W-1:0] STRONG_CONSUME_RST = 14'd792;
    localparam logic [REG_W-1:0] MILD_CONSUME_RST   = 14'd796;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_STRETCH = 2'd1,
        MODE_STARVED = 2'd2
    } mode_t;

    typedef struct packed {
        op_t                op;
        logic [FRAME_W-1:0] frame;
    } item_t;

    typedef struct packed {
        logic [REG_W-1:0] block_frames;
        logic [REG_W-1:0] stretch_frames;
        logic [REG_W-1:0] low_threshold;
        logic [REG_W-1:0] high_threshold;
        logic [REG_W-1:0] strong_consume;
        logic [REG_W-1:0] mild_consume;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [REG_W-1:0] dividend;
        logic [REG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [REG_W-1:0] quotient;
        logic [REG_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== hdl/elastic_audio_fifo_core.sv =====
// ----------------------------------------------------------------------------
// elastic_audio_fifo_core
// ring fifo of stereo frames with block-wise time stretch and underrun
// concealment
// ----------------------------------------------------------------------------
//
// channel  direction  bits          contents (lowest bit first)
// s_*      in         tdata 32      push_frame
//                     tuser 1       operation (0 push, 1 pull)
// m_*      out        tdata 48      out_frame, queued_frames, 2 zero bits
//                     tuser 1       concealed
//                     tlast 1       last_of_block
// cfg_*    in         idx 3, 14     register write, no read-back
//
// a push is written to the ring in the back end directly, a pull reads the ring,
// then loads the output register; the pull that opens a normal or stretch block
// first runs the 14-step divider for consume/frames
// reset: asynchronous active low, clears pointers, block state and registers;
// the ring itself has no reset and needs no clearing pass
// the two-entry input queue keeps taking items, until both entries are full, while
// the back end waits on m_tready; the output register holds one item until it is taken
// RING_DEPTH must be a power of two
//
module elastic_audio_fifo_core
#(
    parameter int RING_DEPTH = eaf_pkg::RING_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [eaf_pkg::FRAME_W-1:0]     s_tdata,   // push_frame
    input  logic [eaf_pkg::TUSER_W-1:0]     s_tuser,   // operation
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [eaf_pkg::TDATA_W-1:0]     m_tdata,   // out_frame, queued_frames
    output logic [eaf_pkg::TUSER_W-1:0]     m_tuser,   // concealed
    output logic                            m_tlast,   // last_of_block
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [eaf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eaf_pkg::REG_W-1:0]       cfg_data
);

    localparam int PAD_W = eaf_pkg::TDATA_W - eaf_pkg::FRAME_W - eaf_pkg::REG_W;

    eaf_pkg::cfg_t               cfg_reg;
    eaf_pkg::item_t              item;
    logic                        item_valid;
    logic                        item_pop;
    eaf_pkg::div_req_t           div_req;
    eaf_pkg::div_rsp_t           div_rsp;
    logic [eaf_pkg::FRAME_W-1:0] out_frame;
    logic                        concealed;
    logic                        last_of_block;
    logic [eaf_pkg::REG_W-1:0]   queued_frames;

    // register file, latched by the back end at each block start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_frames   <= eaf_pkg::BLOCK_FRAMES_RST;
            cfg_reg.stretch_frames <= eaf_pkg::STRETCH_FRAMES_RST;
            cfg_reg.low_threshold  <= eaf_pkg::LOW_THRESHOLD_RST;
            cfg_reg.high_threshold <= eaf_pkg::HIGH_THRESHOLD_RST;
            cfg_reg.strong_consume <= eaf_pkg::STRONG_CONSUME_RST;
            cfg_reg.mild_consume   <= eaf_pkg::MILD_CONSUME_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                eaf_pkg::REG_BLOCK_FRAMES:   cfg_reg.block_frames   <= cfg_data;
                eaf_pkg::REG_STRETCH_FRAMES: cfg_reg.stretch_frames <= cfg_data;
                eaf_pkg::REG_LOW_THRESHOLD:  cfg_reg.low_threshold  <= cfg_data;
                eaf_pkg::REG_HIGH_THRESHOLD: cfg_reg.high_threshold <= cfg_data;
                eaf_pkg::REG_STRONG_CONSUME: cfg_reg.strong_consume <= cfg_data;
                eaf_pkg::REG_MILD_CONSUME:   cfg_reg.mild_consume   <= cfg_data;
                default:                     ;  // unknown index, write dropped
            endcase
        end
    end

    // front end: accept and decode items
    eaf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser[0]),
        .in_frame   (s_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // divider for the per-block index step
    eaf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back end: ring, block sequencing, output register
    eaf_back
    #(
        .RING_DEPTH (RING_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_frame     (out_frame),
        .concealed     (concealed),
        .last_of_block (last_of_block),
        .queued_frames (queued_frames)
    );

    assign m_tdata = {{PAD_W{1'b0}}, queued_frames, out_frame};
    assign m_tuser = concealed;
    assign m_tlast = last_of_block;

endmodule

// ===== hdl/eaf_front.sv =====
// ----------------------------------------------------------------------------
// eaf_front
// input side: takes items, decodes the operation, two-entry queue to the back
// ----------------------------------------------------------------------------
module eaf_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_op,
    input  logic [eaf_pkg::FRAME_W-1:0]  in_frame,
    output logic                         item_valid,
    output eaf_pkg::item_t               item,
    input  logic                         item_pop
);

    eaf_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;
    eaf_pkg::item_t new_item;

    assign in_ready   = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_pop && item_valid;

    always_comb
    begin
        new_item.op    = in_op ? eaf_pkg::OP_PULL : eaf_pkg::OP_PUSH;
        new_item.frame = in_frame;
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next     = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== hdl/eaf_div.sv =====
// ----------------------------------------------------------------------------
// eaf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module eaf_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  eaf_pkg::div_req_t req,
    output eaf_pkg::div_rsp_t rsp
);

    localparam int W     = eaf_pkg::REG_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     quo_next;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       partial;
    logic [W:0]       diff;

    always_comb
    begin
        partial = {rem_reg, quo_reg[W-1]};
        diff    = partial - {1'b0, dsr_reg};
        if (partial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = partial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/eaf_back.sv =====
// ----------------------------------------------------------------------------
// eaf_back
// ring memory, block sequencer and output register
// ----------------------------------------------------------------------------
module eaf_back
#(
    parameter int RING_DEPTH = eaf_pkg::RING_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  eaf_pkg::cfg_t                cfg,
    input  logic                         item_valid,
    input  eaf_pkg::item_t               item,
    output logic                         item_pop,
    output eaf_pkg::div_req_t            div_req,
    input  eaf_pkg::div_rsp_t            div_rsp,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [eaf_pkg::FRAME_W-1:0]  out_frame,
    output logic                         concealed,
    output logic                         last_of_block,
    output logic [eaf_pkg::REG_W-1:0]    queued_frames
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int W     = eaf_pkg::REG_W;
    localparam int CMP_W = PTR_W + W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_DATA = 4'b1000
    } state_t;

    logic [eaf_pkg::FRAME_W-1:0] ring_mem [RING_DEPTH];
    logic [eaf_pkg::FRAME_W-1:0] rdata_reg;

    state_t                      state_reg, state_next;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [eaf_pkg::FRAME_W-1:0] last_frame_reg, last_frame_next;
    logic [W-1:0]                pos_reg, pos_next;
    logic [PTR_W-1:0]            base_reg, base_next;
    logic [W-1:0]                consume_reg, consume_next;
    logic [W-1:0]                length_reg, length_next;
    eaf_pkg::mode_t              mode_reg, mode_next;
    logic [W-1:0]                q0_reg, q0_next;
    logic [W-1:0]                r0_reg, r0_next;
    logic [PTR_W-1:0]            q_reg, q_next;
    logic [W-1:0]                r_reg, r_next;

    logic                        out_valid_reg, out_valid_next;
    logic [eaf_pkg::FRAME_W-1:0] out_frame_reg;
    logic                        conc_reg;
    logic                        last_reg;
    logic [W-1:0]                queued_reg;
    logic                        out_load;
    logic [eaf_pkg::FRAME_W-1:0] ld_frame;
    logic                        ld_conc;

    logic                        mem_we;
    logic                        rd_en;
    logic [PTR_W-1:0]            rd_addr;

    // block start decision
    logic [PTR_W-1:0]            level_now;
    logic [CMP_W-1:0]            level_cmp;
    logic [W-1:0]                frames_now;
    logic [W-1:0]                consume_now;
    eaf_pkg::mode_t              mode_now;
    logic                        starved_now;

    logic                        last;
    logic [W:0]                  pos_inc;
    logic [W:0]                  r_sum;
    logic [CMP_W-1:0]            q0_ext;
    logic [CMP_W-1:0]            consume_ext;
    logic [PTR_W-1:0]            level_after;
    logic [CMP_W-1:0]            level_after_ext;

    function automatic logic [CMP_W-1:0] ext_reg(input logic [W-1:0] value);
        ext_reg = {{PTR_W{1'b0}}, value};
    endfunction

    always_comb
    begin
        level_now  = head_reg - tail_reg;
        level_cmp  = {{W{1'b0}}, level_now};
        frames_now = (cfg.block_frames == '0) ? W'(1) : cfg.block_frames;
        consume_now = frames_now;
        mode_now    = eaf_pkg::MODE_NORMAL;
        if (frames_now == cfg.stretch_frames)
        begin
            if (level_cmp < ext_reg(cfg.low_threshold) &&
                level_cmp >= ext_reg(cfg.strong_consume))
            begin
                consume_now = cfg.strong_consume;
                mode_now    = eaf_pkg::MODE_STRETCH;
            end
            else if (level_cmp < ext_reg(cfg.high_threshold) &&
                     level_cmp >= ext_reg(cfg.mild_consume))
            begin
                consume_now = cfg.mild_consume;
                mode_now    = eaf_pkg::MODE_STRETCH;
            end
        end
        starved_now = (level_cmp < ext_reg(consume_now));
    end

    always_comb
    begin
        pos_inc     = {1'b0, pos_reg} + 1'b1;
        last        = (pos_inc >= {1'b0, length_reg});
        r_sum       = {1'b0, r_reg} + {1'b0, r0_reg};
        q0_ext      = ext_reg(q0_reg);
        consume_ext = ext_reg(consume_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        last_frame_next = last_frame_reg;
        pos_next        = pos_reg;
        base_next       = base_reg;
        consume_next    = consume_reg;
        length_next     = length_reg;
        mode_next       = mode_reg;
        q0_next         = q0_reg;
        r0_next         = r0_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        item_pop        = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = tail_reg;
        div_req.start    = 1'b0;
        div_req.dividend = consume_now;
        div_req.divisor  = frames_now;
        out_load        = 1'b0;
        ld_frame        = rdata_reg;
        ld_conc         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.op == eaf_pkg::OP_PUSH)
                    begin
                        mem_we    = 1'b1;
                        head_next = head_reg + 1'b1;
                        item_pop  = 1'b1;
                    end
                    else if (pos_reg == '0)
                    begin
                        // first pull of a block: latch length, base and mode
                        length_next  = frames_now;
                        base_next    = tail_reg;
                        consume_next = consume_now;
                        q_next       = '0;
                        r_next       = '0;
                        if (starved_now)
                        begin
                            mode_next  = eaf_pkg::MODE_STARVED;
                            rd_en      = 1'b1;
                            rd_addr    = tail_reg;
                            state_next = ST_DATA;
                        end
                        else
                        begin
                            mode_next     = mode_now;
                            div_req.start = 1'b1;
                            state_next    = ST_DIV;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = (mode_reg == eaf_pkg::MODE_STARVED) ?
                                     tail_reg : base_reg + q_reg;
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    q0_next    = div_rsp.quotient;
                    r0_next    = div_rsp.remainder;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = base_reg + q_reg;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    item_pop = 1'b1;
                    if (mode_reg == eaf_pkg::MODE_STARVED)
                    begin
                        if (tail_reg != head_reg)
                        begin
                            last_frame_next = rdata_reg;
                            tail_next       = tail_reg + 1'b1;
                        end
                        else
                        begin
                            ld_frame = last_frame_reg;
                            ld_conc  = 1'b1;
                        end
                    end
                    else
                    begin
                        last_frame_next = rdata_reg;
                        if (last)
                        begin
                            tail_next = base_reg + consume_ext[PTR_W-1:0];
                        end
                        // step the index by consume/frames
                        if (r_sum >= {1'b0, length_reg})
                        begin
                            r_next = W'(r_sum - {1'b0, length_reg});
                            q_next = q_reg + q0_ext[PTR_W-1:0] + 1'b1;
                        end
                        else
                        begin
                            r_next = r_sum[W-1:0];
                            q_next = q_reg + q0_ext[PTR_W-1:0];
                        end
                    end
                    pos_next   = last ? '0 : pos_inc[W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        level_after     = head_reg - tail_next;
        level_after_ext = {{W{1'b0}}, level_after};
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            last_frame_reg <= '0;
            pos_reg        <= '0;
            base_reg       <= '0;
            consume_reg    <= '0;
            length_reg     <= '0;
            mode_reg       <= eaf_pkg::MODE_NORMAL;
            q0_reg         <= '0;
            r0_reg         <= '0;
            q_reg          <= '0;
            r_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            last_frame_reg <= last_frame_next;
            pos_reg        <= pos_next;
            base_reg       <= base_next;
            consume_reg    <= consume_next;
            length_reg     <= length_next;
            mode_reg       <= mode_next;
            q0_reg         <= q0_next;
            r0_reg         <= r0_next;
            q_reg          <= q_next;
            r_reg          <= r_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_frame_reg <= ld_frame;
            conc_reg      <= ld_conc;
            last_reg      <= last;
            queued_reg    <= level_after_ext[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[head_reg] <= item.frame;
        end
        if (rd_en)
        begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_frame     = out_frame_reg;
    assign concealed     = conc_reg;
    assign last_of_block = last_reg;
    assign queued_frames = queued_reg;

endmodule

// ===== hdl/eaf_checker.sv =====
// ----------------------------------------------------------------------------
// eaf_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module eaf_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [eaf_pkg::TDATA_W-1:0] m_tdata,
    input  logic [eaf_pkg::TUSER_W-1:0] m_tuser,
    input  logic                        m_tlast
);

    localparam int QLO = eaf_pkg::FRAME_W;
    localparam int QHI = eaf_pkg::FRAME_W + eaf_pkg::REG_W - 1;

    // no result item once a reset edge has been seen
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result payload changed under stall");

    // a concealed frame is only given when the ring is empty
    a_conceal_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[QHI:QLO] == '0)
        else $error("concealed frame with frames queued");

endmodule

bind elastic_audio_fifo_core eaf_checker u_eaf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for elastic_audio_fifo_core: a driver and a monitor
// around the block, with a cycle-free predictor of the ring, the block modes
// and concealment; random stalls on both streams
// ----------------------------------------------------------------------------
module tb;

    // register indexes past the end of the file, writes there are dropped
    localparam logic [eaf_pkg::CFG_IDX_W-1:0] REG_INDEX_SPARE = 3'd6;
    localparam logic [eaf_pkg::CFG_IDX_W-1:0] REG_INDEX_TOP   = 3'd7;

    localparam int SETTLE_CYCLES  = 40;
    localparam int SEGMENT_ITEMS  = 45;
    localparam int NUM_SEGMENTS   = 6;
    localparam int NOMINAL_FILL   = 800;

    // one expected pull result
    typedef struct {
        logic [eaf_pkg::FRAME_W-1:0] frame;
        logic                        concealed;
        logic                        last_of_block;
        logic [eaf_pkg::REG_W-1:0]   level;
    } pull_out_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [eaf_pkg::FRAME_W-1:0]   s_tdata   = '0;
    logic [eaf_pkg::TUSER_W-1:0]   s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [eaf_pkg::TDATA_W-1:0]   m_tdata;
    logic [eaf_pkg::TUSER_W-1:0]   m_tuser;
    logic                          m_tlast;
    logic                          cfg_wr_en = 1'b0;
    logic [eaf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [eaf_pkg::REG_W-1:0]     cfg_data  = '0;

    elastic_audio_fifo_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state, a mirror of the block's ring and block bookkeeping
    // ------------------------------------------------------------------
    logic [eaf_pkg::FRAME_W-1:0] ring_mem [eaf_pkg::RING_DEPTH_DEF];
    logic [eaf_pkg::REG_W-1:0]   head_ptr      = '0;
    logic [eaf_pkg::REG_W-1:0]   tail_ptr      = '0;
    logic [eaf_pkg::FRAME_W-1:0] held_frame    = '0;
    logic [eaf_pkg::REG_W-1:0]   blk_pos       = '0;
    logic [eaf_pkg::REG_W-1:0]   blk_base      = '0;
    logic [eaf_pkg::REG_W-1:0]   blk_consume   = '0;
    logic [eaf_pkg::REG_W-1:0]   blk_len       = '0;
    eaf_pkg::mode_t              blk_mode      = eaf_pkg::MODE_NORMAL;
    eaf_pkg::cfg_t               cfg_shadow    =
        '{block_frames:   eaf_pkg::BLOCK_FRAMES_RST,
          stretch_frames: eaf_pkg::STRETCH_FRAMES_RST,
          low_threshold:  eaf_pkg::LOW_THRESHOLD_RST,
          high_threshold: eaf_pkg::HIGH_THRESHOLD_RST,
          strong_consume: eaf_pkg::STRONG_CONSUME_RST,
          mild_consume:   eaf_pkg::MILD_CONSUME_RST};

    pull_out_t          frames_due[$];      // pull results still to come out
    eaf_pkg::item_t     pending[$];         // items waiting for the driver

    // statistics and bench control
    int  mismatches      = 0;
    int  n_results       = 0;
    int  n_pushes        = 0;
    int  n_pulls         = 0;
    int  n_full_pushes   = 0;
    int  n_stretched     = 0;
    int  n_starved       = 0;
    int  n_concealed     = 0;
    int  level_guess     = 0;
    bit  gaps_on         = 1'b1;
    bit  in_taken        = 1'b0;
    int  send_gap        = 0;
    int  recv_gap        = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 what, n_results, got, want);
    endtask

    function automatic void apply_reg_write(input logic [eaf_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [eaf_pkg::REG_W-1:0] val);
        case (idx)
            eaf_pkg::REG_BLOCK_FRAMES:   cfg_shadow.block_frames   = val;
            eaf_pkg::REG_STRETCH_FRAMES: cfg_shadow.stretch_frames = val;
            eaf_pkg::REG_LOW_THRESHOLD:  cfg_shadow.low_threshold  = val;
            eaf_pkg::REG_HIGH_THRESHOLD: cfg_shadow.high_threshold = val;
            eaf_pkg::REG_STRONG_CONSUME: cfg_shadow.strong_consume = val;
            eaf_pkg::REG_MILD_CONSUME:   cfg_shadow.mild_consume   = val;
            default: ;          // spare indexes hold nothing
        endcase
    endfunction

    // push: write at head, no full check, so a push into a full ring wraps the level to zero
    function automatic void store_frame(input logic [eaf_pkg::FRAME_W-1:0] frame);
        if (eaf_pkg::REG_W'(head_ptr - tail_ptr) == {eaf_pkg::REG_W{1'b1}})
            n_full_pushes++;
        ring_mem[head_ptr] = frame;
        head_ptr = head_ptr + 1'b1;
        n_pushes++;
    endfunction

    // pull: one output frame of the current block
    function automatic pull_out_t play_out_frame();
        pull_out_t                 res;
        logic [eaf_pkg::REG_W-1:0] qlvl;
        logic [eaf_pkg::REG_W-1:0] len;
        logic [eaf_pkg::REG_W-1:0] consume;
        logic [31:0]               prod;
        logic [31:0]               offset;
        eaf_pkg::mode_t            mode;

        // block opens: latch length, base and consume, pick the mode from the level
        if (blk_pos == 0)
        begin
            len     = (cfg_shadow.block_frames == 0) ? eaf_pkg::REG_W'(1)
                                                     : cfg_shadow.block_frames;
            qlvl    = head_ptr - tail_ptr;
            consume = len;
            mode    = eaf_pkg::MODE_NORMAL;
            if (len == cfg_shadow.stretch_frames)
            begin
                if (qlvl < cfg_shadow.low_threshold && qlvl >= cfg_shadow.strong_consume)
                begin
                    consume = cfg_shadow.strong_consume;
                    mode    = eaf_pkg::MODE_STRETCH;
                end
                else if (qlvl < cfg_shadow.high_threshold &&
                         qlvl >= cfg_shadow.mild_consume)
                begin
                    consume = cfg_shadow.mild_consume;
                    mode    = eaf_pkg::MODE_STRETCH;
                end
            end
            blk_len     = len;
            blk_base    = tail_ptr;
            blk_consume = consume;
            blk_mode    = (qlvl >= consume) ? mode : eaf_pkg::MODE_STARVED;
            if (blk_mode == eaf_pkg::MODE_STRETCH)
                n_stretched++;
            if (blk_mode == eaf_pkg::MODE_STARVED)
                n_starved++;
        end

        res.last_of_block = (blk_pos + 1 >= blk_len);
        res.concealed     = 1'b0;

        if (blk_mode == eaf_pkg::MODE_STARVED)
        begin
            // drain what is there, frames pushed meanwhile included
            if (tail_ptr != head_ptr)
            begin
                res.frame  = ring_mem[tail_ptr];
                held_frame = res.frame;
                tail_ptr   = tail_ptr + 1'b1;
            end
            else
            begin
                res.frame     = held_frame;
                res.concealed = 1'b1;
                n_concealed++;
            end
        end
        else
        begin
            // lower-neighbour pick (floor of pos*consume/len) across the consumed span
            prod       = blk_pos * blk_consume;
            offset     = prod / blk_len;
            res.frame  = ring_mem[blk_base + offset[eaf_pkg::REG_W-1:0]];
            held_frame = res.frame;
            if (res.last_of_block)
                tail_ptr = blk_base + blk_consume;
        end

        blk_pos   = res.last_of_block ? eaf_pkg::REG_W'(0) : blk_pos + 1'b1;
        res.level = head_ptr - tail_ptr;
        n_pulls++;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // monitor and predictor, all sampling at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pull_out_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            // result side first, against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (frames_due.size() == 0)
                    report_mismatch("result with nothing pending",
                                    m_tdata[eaf_pkg::FRAME_W-1:0], '0);
                else
                begin
                    want = frames_due.pop_front();
                    if (m_tdata[eaf_pkg::FRAME_W-1:0] !== want.frame)
                        report_mismatch("out_frame", m_tdata[eaf_pkg::FRAME_W-1:0],
                                        want.frame);
                    if (m_tuser[0] !== want.concealed)
                        report_mismatch("concealed", m_tuser[0], want.concealed);
                    if (m_tlast !== want.last_of_block)
                        report_mismatch("last_of_block", m_tlast, want.last_of_block);
                    if (m_tdata[eaf_pkg::FRAME_W +: eaf_pkg::REG_W] !== want.level)
                        report_mismatch("queued_frames",
                                        m_tdata[eaf_pkg::FRAME_W +: eaf_pkg::REG_W],
                                        want.level);
                end
            end

            // the user is to write registers only while the block is idle; the block does not enforce it
            if (cfg_wr_en)
                apply_reg_write(cfg_index, cfg_data);

            in_taken = s_tvalid && s_tready;
            if (in_taken)
            begin
                if (s_tuser[0] == eaf_pkg::OP_PUSH)
                    store_frame(s_tdata);
                else
                    frames_due.push_back(play_out_frame());
            end
        end
    end

    // ------------------------------------------------------------------
    // input driver, fed from the pending queue, changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        eaf_pkg::item_t nxt;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (gaps_on && pending.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                // idle burst of random length, this one included
                send_gap = $urandom_range(0, 18);
                s_tvalid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                nxt = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.frame;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side back-pressure, in bursts as well
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                m_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_push(input logic [eaf_pkg::FRAME_W-1:0] frame);
        eaf_pkg::item_t it;
        it.op    = eaf_pkg::OP_PUSH;
        it.frame = frame;
        pending.push_back(it);
        level_guess++;
    endtask

    // pulls carry random data that the block must ignore
    task automatic add_pull();
        eaf_pkg::item_t it;
        it.op    = eaf_pkg::OP_PULL;
        it.frame = $urandom();
        pending.push_back(it);
        if (level_guess > 0)
            level_guess--;
    endtask

    // everything sent and answered, then let a block opening with no result finish
    task automatic wait_idle();
        while (pending.size() != 0 || s_tvalid || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(input logic [eaf_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= eaf_pkg::REG_W'(val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_all(input int frames, input int stretch, input int lo,
                           input int hi, input int strong_c, input int mild_c);
        set_reg(eaf_pkg::REG_BLOCK_FRAMES,   frames);
        set_reg(eaf_pkg::REG_STRETCH_FRAMES, stretch);
        set_reg(eaf_pkg::REG_LOW_THRESHOLD,  lo);
        set_reg(eaf_pkg::REG_HIGH_THRESHOLD, hi);
        set_reg(eaf_pkg::REG_STRONG_CONSUME, strong_c);
        set_reg(eaf_pkg::REG_MILD_CONSUME,   mild_c);
    endtask

    // pull out the rest of a block left open by a ragged run
    task automatic close_block();
        if (blk_pos != 0)
            repeat (int'(blk_len) - int'(blk_pos)) add_pull();
    endtask

    // mostly whole blocks after a refill toward a random level, some noise
    task automatic random_segment(input int n_items, input int bl);
        int made;
        int target;
        int run;
        made = 0;
        while (made < n_items)
        begin
            target = $urandom_range(0, 3 * bl + 12);
            while (level_guess < target)
            begin
                add_push($urandom());
                made++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                run = $urandom_range(1, 2 * bl);
                repeat (run)
                begin
                    if ($urandom_range(0, 1) != 0)
                        add_push($urandom());
                    else
                        add_pull();
                    made++;
                end
            end
            else
            begin
                repeat (bl)
                begin
                    add_pull();
                    made++;
                    if ($urandom_range(0, 5) == 0)
                    begin
                        add_push($urandom());
                        made++;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int bl;
        int lo;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // zero block length acts as one; the first pull finds the ring empty
        set_reg(eaf_pkg::REG_BLOCK_FRAMES, 0);
        set_reg(eaf_pkg::REG_STRETCH_FRAMES, 0);
        add_pull();
        add_push(32'h0000_0000);
        add_push(32'hFFFF_FFFF);
        add_pull();
        add_pull();
        add_pull();
        add_push(32'hA5A5_A5A5);
        add_push(32'h5A5A_5A5A);
        wait_idle();

        // mild consume above the block length, writes past the file dropped
        set_all(4, 4, 4, 9, 2, 7);
        set_reg(REG_INDEX_SPARE, 1);
        set_reg(REG_INDEX_TOP, 16383);
        repeat (6) add_push($urandom());
        repeat (4) add_pull();
        add_pull();
        wait_idle();

        // new length mid-block waits for the next block; starved block takes a late push
        set_reg(eaf_pkg::REG_BLOCK_FRAMES, 2);
        add_pull();
        add_push($urandom());
        add_pull();
        add_pull();
        wait_idle();

        // one reset-size block at a level that picks the strong stretch
        set_all(eaf_pkg::BLOCK_FRAMES_RST, eaf_pkg::STRETCH_FRAMES_RST,
                eaf_pkg::LOW_THRESHOLD_RST, eaf_pkg::HIGH_THRESHOLD_RST,
                eaf_pkg::STRONG_CONSUME_RST, eaf_pkg::MILD_CONSUME_RST);
        close_block();
        repeat (NOMINAL_FILL) add_push($urandom());
        repeat (NOMINAL_FILL) add_pull();
        wait_idle();

        // random part over several settings; the last one runs without stalls
        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            case (seg)
                0: begin bl = 8; set_all(8, 8, 12, 20, 6, 7); end
                1: begin bl = 5; set_all(5, 5, 9, 16, 7, 9); end
                3: begin bl = 1; set_all(1, 1, 16383, 16383, 1, 16383); end
                4: begin bl = 1; set_all(0, 1, 0, 16383, 16383, 2); end
                default:
                begin
                    bl = $urandom_range(1, 12);
                    lo = $urandom_range(0, 30);
                    set_all(bl, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : bl,
                            lo, $urandom_range(lo, 40), $urandom_range(1, bl + 6),
                            $urandom_range(1, bl + 6));
                end
            endcase
            close_block();
            level_guess = int'(eaf_pkg::REG_W'(head_ptr - tail_ptr));
            gaps_on     = (seg < NUM_SEGMENTS - 1) && ($urandom_range(0, 3) != 0);
            random_segment(SEGMENT_ITEMS, bl);
            wait_idle();
        end

        $display("run covered %0d pushes (%0d into a full ring) and %0d pulls",
                 n_pushes, n_full_pushes, n_pulls);
        $display("%0d stretched and %0d starved blocks, %0d concealed frames, %0d mismatches",
                 n_stretched, n_starved, n_concealed, mismatches);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", frames_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

// ===== elastic_audio_fifo_core.f =====
hdl/eaf_pkg.sv
hdl/eaf_front.sv
hdl/eaf_div.sv
hdl/eaf_back.sv
hdl/elastic_audio_fifo_core.sv
hdl/eaf_checker.sv
test/tb.sv
